// ----- sv/gqi_pkg.sv -----
package gqi_pkg;

    // one input transfer
    typedef struct packed {
        logic               cmd;
        logic        [15:0] step_time;
        logic signed [15:0] rate_x;
        logic signed [15:0] rate_y;
        logic signed [15:0] rate_z;
        logic signed [15:0] load_w;
        logic signed [15:0] load_x;
        logic signed [15:0] load_y;
        logic signed [15:0] load_z;
    } t_in_item;

    // one result transfer
    typedef struct packed {
        logic signed [15:0] quat_w;
        logic signed [15:0] quat_x;
        logic signed [15:0] quat_y;
        logic signed [15:0] quat_z;
        logic               zero_norm;
    } t_out_item;

    localparam logic CMD_INTEGRATE = 1'b0;
    localparam logic CMD_LOAD      = 1'b1;

    // output clamp, Q1.14 unity
    localparam logic signed [15:0] OUT_ONE = 16'sd16384;

endpackage

// ----- sv/gqi_if.sv -----
interface gqi_in_if;
    import gqi_pkg::*;
    logic     valid;
    logic     ready;
    t_in_item data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface gqi_out_if;
    import gqi_pkg::*;
    logic      valid;
    logic      ready;
    t_out_item data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ----- sv/gyro_quaternion_integrator.sv -----
// One item at a time: the input is ready only in idle, which is entered when the result is
// registered, once the output register is free; a zero norm skips the square root and divider.
// The serial square root and divider dominate, with one shared multiplier.
// Reset (synchronous, active low) sets the attitude to identity and empties the output.
module gyro_quaternion_integrator #(
    parameter int QUAT_WIDTH = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    gqi_in_if.sink    i_in,
    gqi_out_if.source o_out
);
    import gqi_pkg::*;

    localparam int W    = QUAT_WIDTH;
    localparam int F    = W - 2;
    localparam int PW   = W + 2;                  // pre-normalisation component
    localparam int MW   = (PW > 30) ? PW : 30;    // magnitude register
    localparam int DW   = W + 20;                 // derivative accumulator
    localparam int TW   = DW - 10;                // rounded derivative
    localparam int AW   = (TW > 31) ? TW : 31;
    localparam int BW   = 31;
    localparam int PRW  = AW + BW;
    localparam int SW   = PRW + 1;
    localparam int NW   = 31 + F;                 // dividend
    localparam int OWD  = W + 16;
    localparam int SH_R = (F >= 14) ? F - 14 : 0;
    localparam int SH_L = (F < 14) ? 14 - F : 0;

    localparam logic signed [W-1:0]   QONE = W'(1) << F;
    localparam logic signed [63:0]    QMAX = (64'sd1 <<< (W - 1)) - 64'sd1;
    localparam logic signed [63:0]    QMIN = -(64'sd1 <<< (W - 1));
    localparam logic signed [OWD-1:0] HALF = (OWD'(1) << SH_R) >> 1;
    localparam logic        [F:0]     QCAP = (F + 1)'(1) << F;

    typedef enum logic [9:0] {
        S_IDLE  = 10'b0000000001,
        S_MAC   = 10'b0000000010,
        S_SCALE = 10'b0000000100,
        S_PREP  = 10'b0000001000,
        S_NORM  = 10'b0000010000,
        S_SQ    = 10'b0000100000,
        S_SQRT  = 10'b0001000000,
        S_DIVI  = 10'b0010000000,
        S_DIV   = 10'b0100000000,
        S_DONE  = 10'b1000000000
    } t_state;

    t_state                r_state;
    t_in_item              r_in;
    logic signed [W-1:0]   r_att [4];
    logic signed [PW-1:0]  r_p   [4];
    logic        [MW-1:0]  r_mag [4];
    logic                  r_neg [4];
    logic        [1:0]     r_comp;
    logic        [1:0]     r_term;
    logic        [5:0]     r_cnt;
    logic signed [DW-1:0]  r_acc;
    logic signed [TW-1:0]  r_t;
    logic        [62:0]    r_sum;
    logic        [63:0]    r_n;
    logic        [63:0]    r_r;
    logic        [63:0]    r_bit;
    logic        [31:0]    r_rem;
    logic        [NW-1:0]  r_num;
    logic        [F:0]     r_q;
    logic                  r_zero;
    logic                  r_ov;
    t_out_item             r_out;

    // derivative term selection
    logic [1:0] m_qs;
    logic [1:0] m_rs;
    logic       m_ng;
    always_comb begin
        m_qs = 2'd0;
        m_rs = 2'd0;
        m_ng = 1'b0;
        unique case ({r_comp, r_term})
            4'h0: begin m_qs = 2'd1; m_rs = 2'd0; m_ng = 1'b1; end
            4'h1: begin m_qs = 2'd2; m_rs = 2'd1; m_ng = 1'b1; end
            4'h2: begin m_qs = 2'd3; m_rs = 2'd2; m_ng = 1'b1; end
            4'h4: begin m_qs = 2'd0; m_rs = 2'd0; m_ng = 1'b0; end
            4'h5: begin m_qs = 2'd2; m_rs = 2'd2; m_ng = 1'b0; end
            4'h6: begin m_qs = 2'd3; m_rs = 2'd1; m_ng = 1'b1; end
            4'h8: begin m_qs = 2'd0; m_rs = 2'd1; m_ng = 1'b0; end
            4'h9: begin m_qs = 2'd1; m_rs = 2'd2; m_ng = 1'b1; end
            4'hA: begin m_qs = 2'd3; m_rs = 2'd0; m_ng = 1'b0; end
            4'hC: begin m_qs = 2'd0; m_rs = 2'd2; m_ng = 1'b0; end
            4'hD: begin m_qs = 2'd1; m_rs = 2'd1; m_ng = 1'b0; end
            4'hE: begin m_qs = 2'd2; m_rs = 2'd0; m_ng = 1'b1; end
            default: begin m_qs = 2'd0; m_rs = 2'd0; m_ng = 1'b0; end
        endcase
    end

    logic signed [15:0] m_rate;
    always_comb begin
        unique case (m_rs)
            2'd0:    m_rate = r_in.rate_x;
            2'd1:    m_rate = r_in.rate_y;
            default: m_rate = r_in.rate_z;
        endcase
    end

    // shared multiplier
    logic signed [AW-1:0]  mul_a;
    logic signed [BW-1:0]  mul_b;
    logic signed [PRW-1:0] prod;
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (r_state)
            S_MAC: begin
                mul_a = AW'(r_att[m_qs]);
                mul_b = BW'(m_rate);
            end
            S_SCALE: begin
                mul_a = AW'(r_t);
                mul_b = $signed(BW'(r_in.step_time));
            end
            S_SQ: begin
                mul_a = $signed(AW'(r_mag[r_comp][29:0]));
                mul_b = $signed(BW'(r_mag[r_comp][29:0]));
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        prod = PRW'(mul_a) * PRW'(mul_b);
    end

    // accumulate and round derivative
    logic signed [DW-1:0] acc_n;
    logic signed [DW-1:0] acc_r;
    always_comb begin
        acc_n = (r_term == 2'd0) ? '0 : r_acc;
        acc_n = m_ng ? acc_n - prod[DW-1:0] : acc_n + prod[DW-1:0];
        acc_r = (acc_n + DW'(512)) >>> 10;
    end

    // scale by step time, add and saturate
    logic signed [SW-1:0] sc_r;
    logic signed [SW-1:0] sc_s;
    logic signed [W-1:0]  sc_q;
    always_comb begin
        sc_r = (SW'(prod) + (SW'(1) <<< 16)) >>> 17;
        sc_s = sc_r + SW'(r_att[r_comp]);
        if (sc_s > SW'(QMAX)) begin
            sc_q = QMAX[W-1:0];
        end else if (sc_s < SW'(QMIN)) begin
            sc_q = QMIN[W-1:0];
        end else begin
            sc_q = sc_s[W-1:0];
        end
    end

    // load conversion from frac 13
    function automatic logic signed [PW-1:0] load_conv(input logic signed [15:0] v);
        logic signed [PW+15:0] e;
        e = (PW + 16)'(v);
        if (F >= 13) begin
            e = e <<< (F - 13);
        end else begin
            e = (e + ((PW + 16)'(1) << (12 - F))) >>> (13 - F);
        end
        return e[PW-1:0];
    endfunction

    // magnitude OR gives the same leading one as the maximum
    logic [MW-1:0] orv;
    always_comb begin
        orv = r_mag[0] | r_mag[1] | r_mag[2] | r_mag[3];
    end

    // square root step
    logic [63:0] sq_t;
    always_comb begin
        sq_t = r_r + r_bit;
    end

    // division setup and step
    logic [31:0]   s_val;
    logic [NW-1:0] dv_n;
    logic [32:0]   dv_rem2;
    logic          dv_ge;
    logic [F:0]    dv_q;
    logic [F:0]    dv_qc;
    logic [W-1:0]  dv_qe;
    always_comb begin
        s_val   = r_r[31:0];
        dv_n    = (NW'(r_mag[r_comp][29:0]) << F) + NW'(s_val >> 1);
        dv_rem2 = {r_rem, r_num[F]};
        dv_ge   = dv_rem2 >= {1'b0, s_val};
        if (F > 0) begin
            dv_q = {r_q[F-1:0], dv_ge};
        end else begin
            dv_q = dv_ge;
        end
        dv_qc = (dv_q > QCAP) ? QCAP : dv_q;
        dv_qe = W'(dv_qc);
    end

    // output conversion to Q1.14 with clamp
    function automatic logic signed [15:0] out_conv(input logic signed [W-1:0] x);
        logic signed [OWD-1:0] e;
        e = OWD'(x);
        e = ((e + HALF) >>> SH_R) <<< SH_L;
        if (e > OWD'(OUT_ONE)) begin
            e = OWD'(OUT_ONE);
        end else if (e < -OWD'(OUT_ONE)) begin
            e = -OWD'(OUT_ONE);
        end
        return e[15:0];
    endfunction

    assign i_in.ready  = (r_state == S_IDLE);
    assign o_out.valid = r_ov;
    assign o_out.data  = r_out;

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ov     <= 1'b0;
            r_att[0] <= QONE;
            r_att[1] <= '0;
            r_att[2] <= '0;
            r_att[3] <= '0;
            r_comp   <= '0;
            r_term   <= '0;
            r_cnt    <= '0;
        end else begin
            // output register: load a new result or drop a taken one
            if (r_state == S_DONE && (!r_ov || o_out.ready)) begin
                r_ov <= 1'b1;
            end else if (o_out.ready && r_ov) begin
                r_ov <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_in.valid) begin
                        r_in   <= i_in.data;
                        r_comp <= '0;
                        r_term <= '0;
                        if (i_in.data.cmd == CMD_LOAD) begin
                            r_p[0]  <= load_conv(i_in.data.load_w);
                            r_p[1]  <= load_conv(i_in.data.load_x);
                            r_p[2]  <= load_conv(i_in.data.load_y);
                            r_p[3]  <= load_conv(i_in.data.load_z);
                            r_state <= S_PREP;
                        end else begin
                            r_state <= S_MAC;
                        end
                    end
                end
                S_MAC: begin
                    r_acc <= acc_n;
                    if (r_term == 2'd2) begin
                        r_t     <= acc_r[TW-1:0];
                        r_state <= S_SCALE;
                    end else begin
                        r_term <= r_term + 2'd1;
                    end
                end
                S_SCALE: begin
                    r_p[r_comp] <= PW'(sc_q);
                    r_term      <= '0;
                    r_comp      <= r_comp + 2'd1;
                    r_state     <= (r_comp == 2'd3) ? S_PREP : S_MAC;
                end
                S_PREP: begin
                    for (int i = 0; i < 4; i++) begin
                        r_neg[i] <= r_p[i][PW-1];
                        r_mag[i] <= r_p[i][PW-1] ? MW'(-r_p[i]) : MW'(r_p[i]);
                    end
                    r_sum   <= '0;
                    r_comp  <= '0;
                    r_state <= S_NORM;
                end
                S_NORM: begin
                    if (orv == '0) begin
                        r_att[0] <= QONE;
                        r_att[1] <= '0;
                        r_att[2] <= '0;
                        r_att[3] <= '0;
                        r_zero   <= 1'b1;
                        r_state  <= S_DONE;
                    end else if ((orv >> 30) != '0) begin
                        for (int i = 0; i < 4; i++) r_mag[i] <= r_mag[i] >> 1;
                    end else if (!orv[29]) begin
                        for (int i = 0; i < 4; i++) r_mag[i] <= r_mag[i] << 1;
                    end else begin
                        r_zero  <= 1'b0;
                        r_state <= S_SQ;
                    end
                end
                S_SQ: begin
                    r_sum  <= r_sum + {1'b0, prod};
                    r_comp <= r_comp + 2'd1;
                    if (r_comp == 2'd3) begin
                        r_n     <= {1'b0, r_sum + {1'b0, prod}};
                        r_r     <= '0;
                        r_bit   <= 64'd1 << 62;
                        r_state <= S_SQRT;
                    end
                end
                S_SQRT: begin
                    if (r_n >= sq_t) begin
                        r_n <= r_n - sq_t;
                        r_r <= (r_r >> 1) + r_bit;
                    end else begin
                        r_r <= r_r >> 1;
                    end
                    r_bit <= r_bit >> 2;
                    if (r_bit == 64'd1) begin
                        r_comp  <= '0;
                        r_state <= S_DIVI;
                    end
                end
                S_DIVI: begin
                    r_rem   <= 32'(dv_n >> (F + 1));
                    r_num   <= dv_n;
                    r_q     <= '0;
                    r_cnt   <= 6'(F);
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    r_rem <= dv_ge ? 32'(dv_rem2 - {1'b0, s_val}) : dv_rem2[31:0];
                    r_q   <= dv_q;
                    r_num <= r_num << 1;
                    r_cnt <= r_cnt - 6'd1;
                    if (r_cnt == '0) begin
                        r_att[r_comp] <= r_neg[r_comp] ? -$signed(dv_qe) : $signed(dv_qe);
                        r_comp        <= r_comp + 2'd1;
                        r_state       <= (r_comp == 2'd3) ? S_DONE : S_DIVI;
                    end
                end
                S_DONE: begin
                    if (!r_ov || o_out.ready) begin
                        r_out.quat_w    <= out_conv(r_att[0]);
                        r_out.quat_x    <= out_conv(r_att[1]);
                        r_out.quat_y    <= out_conv(r_att[2]);
                        r_out.quat_z    <= out_conv(r_att[3]);
                        r_out.zero_norm <= r_zero;
                        r_state         <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

// ----- dv/gqi_checker.sv -----
`timescale 1ns / 1ps

module gqi_checker (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic             i_in_ready,
    input  gqi_pkg::t_in_item  i_in_data,
    input  logic             i_out_valid,
    input  logic             i_out_ready,
    input  gqi_pkg::t_out_item i_out_data,
    output int               o_errors,
    output int               o_pending
);
    import gqi_pkg::*;

    localparam int FRAC = 14;

    longint attitude_q[4];
    t_out_item expected_quats[$];

    function automatic longint rshift_round(longint v, int n);
        if (n == 0) return v;
        return (v + (longint'(1) << (n - 1))) >>> n;
    endfunction

    function automatic longint isqrt(longint unsigned n);
        longint unsigned r, bit_val;
        r = 0;
        bit_val = 64'd1 << 62;
        while (bit_val > n) bit_val >>= 2;
        while (bit_val != 0) begin
            if (n >= r + bit_val) begin
                n -= r + bit_val;
                r = (r >> 1) + bit_val;
            end else begin
                r >>= 1;
            end
            bit_val >>= 2;
        end
        return longint'(r);
    endfunction

    function automatic longint sat16(longint v);
        if (v > 32767) return 32767;
        if (v < -32768) return -32768;
        return v;
    endfunction

    // advance the attitude by one transfer and return the output
    function automatic t_out_item update_attitude(t_in_item it);
        longint p[4], d[4], g[3], q[4];
        longint unsigned mag[4], m, sum, s, r;
        bit neg[4];
        int len;
        t_out_item res;
        q = attitude_q;
        res = '0;
        if (it.cmd == CMD_INTEGRATE) begin
            g[0] = it.rate_x; g[1] = it.rate_y; g[2] = it.rate_z;
            d[0] = -q[1]*g[0] - q[2]*g[1] - q[3]*g[2];
            d[1] =  q[0]*g[0] + q[2]*g[2] - q[3]*g[1];
            d[2] =  q[0]*g[1] - q[1]*g[2] + q[3]*g[0];
            d[3] =  q[0]*g[2] + q[1]*g[1] - q[2]*g[0];
            for (int i = 0; i < 4; i++)
                p[i] = sat16(q[i] + rshift_round(rshift_round(d[i], 10)
                                                 * longint'(it.step_time), 17));
        end else begin
            p[0] = longint'(it.load_w) <<< 1; p[1] = longint'(it.load_x) <<< 1;
            p[2] = longint'(it.load_y) <<< 1; p[3] = longint'(it.load_z) <<< 1;
        end
        m = 0;
        for (int i = 0; i < 4; i++) begin
            neg[i] = p[i] < 0;
            mag[i] = neg[i] ? -p[i] : p[i];
            if (mag[i] > m) m = mag[i];
        end
        if (m == 0) begin
            attitude_q = '{longint'(1) << FRAC, 0, 0, 0};
            res.zero_norm = 1'b1;
        end else begin
            len = 0;
            while ((m >> len) != 0) len++;
            sum = 0;
            for (int i = 0; i < 4; i++) begin
                if (len > 30) mag[i] >>= (len - 30);
                else mag[i] <<= (30 - len);
                sum += mag[i] * mag[i];
            end
            s = isqrt(sum);
            for (int i = 0; i < 4; i++) begin
                r = ((mag[i] << FRAC) + s / 2) / s;
                if (r > (64'd1 << FRAC)) r = 64'd1 << FRAC;
                attitude_q[i] = neg[i] ? -longint'(r) : longint'(r);
            end
        end
        res.quat_w = 16'(attitude_q[0]); res.quat_x = 16'(attitude_q[1]);
        res.quat_y = 16'(attitude_q[2]); res.quat_z = 16'(attitude_q[3]);
        return res;
    endfunction

    // predict on input transfers, compare on output transfers
    always @(posedge i_clk) begin
        t_out_item exp_q;
        int        errs;
        errs = 0;
        if (!i_rst_n) begin
            attitude_q = '{longint'(1) << FRAC, 0, 0, 0};
            expected_quats.delete();
            o_errors  <= 0;
            o_pending <= 0;
        end else begin
            if (i_in_valid && i_in_ready) expected_quats.push_back(update_attitude(i_in_data));
            if (i_out_valid && i_out_ready) begin
                if (expected_quats.size() == 0) begin
                    $error("unexpected result transfer");
                    errs = errs + 1;
                end else begin
                    exp_q = expected_quats.pop_front();
                    if (exp_q.quat_w !== i_out_data.quat_w) begin
                        $error("quat_w exp %0d got %0d", exp_q.quat_w, i_out_data.quat_w);
                        errs = errs + 1;
                    end
                    if (exp_q.quat_x !== i_out_data.quat_x) begin
                        $error("quat_x exp %0d got %0d", exp_q.quat_x, i_out_data.quat_x);
                        errs = errs + 1;
                    end
                    if (exp_q.quat_y !== i_out_data.quat_y) begin
                        $error("quat_y exp %0d got %0d", exp_q.quat_y, i_out_data.quat_y);
                        errs = errs + 1;
                    end
                    if (exp_q.quat_z !== i_out_data.quat_z) begin
                        $error("quat_z exp %0d got %0d", exp_q.quat_z, i_out_data.quat_z);
                        errs = errs + 1;
                    end
                    if (exp_q.zero_norm !== i_out_data.zero_norm) begin
                        $error("zero_norm exp %0d got %0d", exp_q.zero_norm,
                               i_out_data.zero_norm);
                        errs = errs + 1;
                    end
                end
            end
            o_errors  <= o_errors + errs;
            o_pending <= expected_quats.size();
        end
    end

endmodule

// ----- dv/tb_gyro_quaternion_integrator.sv -----
`timescale 1ns / 1ps

module tb_gyro_quaternion_integrator;
    import gqi_pkg::*;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    int   errors, pending;
    int   idle_pct = 0;
    int   stall_pct = 0;

    gqi_in_if  in_ch ();
    gqi_out_if out_ch ();

    gyro_quaternion_integrator dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch.sink),
        .o_out   (out_ch.source)
    );

    gqi_checker chk (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_ch.valid),
        .i_in_ready  (in_ch.ready),
        .i_in_data   (in_ch.data),
        .i_out_valid (out_ch.valid),
        .i_out_ready (out_ch.ready),
        .i_out_data  (out_ch.data),
        .o_errors    (errors),
        .o_pending   (pending)
    );

    always #2 i_clk = ~i_clk;

    // receiver stalls
    always @(posedge i_clk) begin
        out_ch.ready <= ($urandom_range(99) >= stall_pct);
    end

    initial begin
        in_ch.valid  = 1'b0;
        in_ch.data   = '0;
        out_ch.ready = 1'b0;
    end

    function automatic logic [15:0] edgy16();
        case ($urandom_range(5))
            0: return 16'h7FFF;
            1: return 16'h8000;
            2: return 16'h0000;
            3: return 16'($urandom_range(63)) - 16'd32;
            default: return 16'($urandom);
        endcase
    endfunction

    // one transfer on the input channel, with optional gap first
    task automatic send_item(t_in_item it);
        while ($urandom_range(99) < idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.data  <= it;
        do @(posedge i_clk); while (!in_ch.ready);
    endtask

    task automatic send_load(logic [15:0] w, x, y, z);
        t_in_item it;
        it = '0;
        it.cmd = CMD_LOAD; it.load_w = w; it.load_x = x; it.load_y = y; it.load_z = z;
        it.step_time = 16'($urandom); it.rate_x = 16'($urandom);
        send_item(it);
    endtask

    task automatic send_integrate(logic [15:0] dt, gx, gy, gz);
        t_in_item it;
        it = '0;
        it.cmd = CMD_INTEGRATE; it.step_time = dt;
        it.rate_x = gx; it.rate_y = gy; it.rate_z = gz;
        it.load_w = 16'($urandom); it.load_z = 16'($urandom);
        send_item(it);
    endtask

    task automatic random_item();
        if ($urandom_range(9) < 2)
            send_load(edgy16(), edgy16(), edgy16(), edgy16());
        else if ($urandom_range(3) == 0)
            send_integrate(edgy16(), edgy16(), edgy16(), edgy16());
        else
            send_integrate(16'($urandom_range(2000)), 16'($urandom), 16'($urandom),
                           16'($urandom));
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: identity integration, extremes, zero norm, negative loads
        send_integrate(16'h0000, 16'h7FFF, 16'h8000, 16'h0001);
        send_integrate(16'hFFFF, 16'h7FFF, 16'h7FFF, 16'h7FFF);
        send_integrate(16'hFFFF, 16'h8000, 16'h8000, 16'h8000);
        send_integrate(16'h0001, 16'hFFFF, 16'h0000, 16'h0000);
        send_load(16'h0000, 16'h0000, 16'h0000, 16'h0000);
        send_load(16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000);
        send_load(16'h8000, 16'h0000, 16'h0000, 16'h0000);
        send_load(16'h0001, 16'h0000, 16'h0000, 16'h0000);
        send_load(16'hFFFF, 16'h0001, 16'hFFFF, 16'h0001);
        send_load(16'h2000, 16'h2000, 16'h2000, 16'h2000);
        send_integrate(16'hFFFF, 16'h7FFF, 16'h8000, 16'h7FFF);
        send_load(16'h0000, 16'h0000, 16'h0000, 16'h0000);
        send_integrate(16'h8000, 16'h0400, 16'hFC00, 16'h0200);
        send_load(16'h0000, 16'h0000, 16'h0000, 16'h0003);
        send_integrate(16'hFFFF, 16'h0000, 16'h0000, 16'h0000);

        // hold off until the block has drained
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);

        // random phases: none, sender idle, receiver stall, both
        for (int ph = 0; ph < 4; ph++) begin
            idle_pct  = (ph == 1) ? 72 : (ph == 3) ? 37 : 0;
            stall_pct = (ph == 2) ? 72 : (ph == 3) ? 37 : 0;
            repeat (385) random_item();
        end

        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        if (errors == 0 && pending == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    initial begin
        #10_000_000;
        $display("FAILURE");
        $finish;
    end

endmodule

// ----- filelist.f -----
sv/gqi_pkg.sv
sv/gqi_if.sv
sv/gyro_quaternion_integrator.sv
dv/gqi_checker.sv
dv/tb_gyro_quaternion_integrator.sv
